[src/aaf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaf_pkg
// Shared types and constants for the analog axis filter.
// ----------------------------------------------------------------------------
package aaf_pkg;

    localparam int DATA_W     = 16;
    localparam int CNT_W      = 7;
    localparam int SUM_W      = 23;
    localparam int MAX_KERNEL = 64;
    localparam int DIV_W      = SUM_W - 1;
    localparam int STEP_W     = $clog2(DIV_W);
    localparam int ADDR_W     = 5;
    localparam int PDATA_W    = 32;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_PASS = 2'd1,
        MODE_AVG  = 2'd2,
        MODE_LAST = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_LOWER  = 3'd1,
        REG_UPPER  = 3'd2,
        REG_DEAD   = 3'd3,
        REG_KERNEL = 3'd4
    } reg_idx_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [DATA_W-1:0]  lower;
        logic signed [DATA_W-1:0]  upper;
        logic        [DATA_W-1:0]  dead;
        logic        [CNT_W-1:0]   kernel;
        logic                      kernel_wr;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DIV_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

endpackage

[src/analog_axis_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_axis_filter_top
// Axis sample conditioner: dead zone, bound clamp, block average/last, pass-through.
//
//  port group | dir | handshake        | payload
//  s_         | in  | s_valid/s_ready  | s_sample (16b signed)
//  m_         | out | m_valid/m_ready  | m_filtered_value (16b signed)
//  apb        | in  | psel/penable     | paddr, pwdata, prdata
//
//  A block end in average mode with kernel > 1 runs the serial divider,
//  which takes 22 steps; s_ready is low meanwhile.
//  Reset is synchronous on aresetn; state and config go to reset values.
//  A result waits in the output register; in idle, m_ready high keeps s_ready high.
// ----------------------------------------------------------------------------
module analog_axis_filter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [aaf_pkg::DATA_W-1:0] s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [aaf_pkg::DATA_W-1:0] m_filtered_value,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aaf_pkg::ADDR_W-1:0]        paddr,
    input  logic [aaf_pkg::PDATA_W-1:0]       pwdata,
    output logic [aaf_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } state_t;

    aaf_pkg::cfg_t      cfg;
    aaf_pkg::div_req_t  div_req;
    logic               div_done;
    logic signed [aaf_pkg::DATA_W-1:0] div_q;

    state_t                              state_reg, state_next;
    logic                                in_dz_reg, in_dz_next;
    logic                                below_reg, below_next;
    logic                                above_reg, above_next;
    logic        [aaf_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic signed [aaf_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [aaf_pkg::DATA_W-1:0]   out_data_reg, out_data_next;

    logic                                s_fire;
    logic                                out_free;
    logic        [aaf_pkg::DATA_W:0]     mag;
    logic                                dz_hit;
    logic signed [aaf_pkg::DATA_W-1:0]   s1, s2;
    logic signed [aaf_pkg::SUM_W-1:0]    sum_add, sum_abs;
    logic        [aaf_pkg::CNT_W-1:0]    cnt_inc;

    aaf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aaf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;

    assign mag     = s_sample[aaf_pkg::DATA_W-1] ? -{s_sample[aaf_pkg::DATA_W-1], s_sample}
                                                 :  {s_sample[aaf_pkg::DATA_W-1], s_sample};
    assign dz_hit  = mag < {1'b0, cfg.dead};
    assign s1      = dz_hit ? '0 : s_sample;
    assign s2      = (s1 < cfg.lower) ? cfg.lower :
                     (s1 > cfg.upper) ? cfg.upper : s1;
    assign sum_add = sum_reg + aaf_pkg::SUM_W'(s2);
    assign sum_abs = sum_add[aaf_pkg::SUM_W-1] ? -sum_add : sum_add;
    assign cnt_inc = cnt_reg + 1'b1;

    always_comb begin
        state_next     = state_reg;
        in_dz_next     = in_dz_reg;
        below_next     = below_reg;
        above_next     = above_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        div_req.start    = 1'b0;
        div_req.neg      = sum_add[aaf_pkg::SUM_W-1];
        div_req.dividend = sum_abs[aaf_pkg::DIV_W-1:0];
        div_req.divisor  = cfg.kernel;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    priority case (cfg.mode)
                        aaf_pkg::MODE_NONE: ;
                        aaf_pkg::MODE_PASS: begin
                            out_valid_next = 1'b1;
                            out_data_next  = s_sample;
                        end
                        default: begin
                            if (!(dz_hit && in_dz_reg)) begin
                                in_dz_next = dz_hit;
                                priority if (s1 < cfg.lower) begin
                                    below_next = 1'b1;
                                    above_next = 1'b0;
                                end else if (s1 > cfg.upper) begin
                                    above_next = 1'b1;
                                    below_next = 1'b0;
                                end else begin
                                    below_next = 1'b0;
                                    above_next = 1'b0;
                                end
                                if (!((s1 < cfg.lower && below_reg) ||
                                      (s1 >= cfg.lower && s1 > cfg.upper && above_reg))) begin
                                    if (cnt_inc < cfg.kernel) begin
                                        cnt_next = cnt_inc;
                                        sum_next = sum_add;
                                    end else begin
                                        cnt_next = '0;
                                        sum_next = '0;
                                        if (cfg.kernel > aaf_pkg::CNT_W'(1) &&
                                            cfg.mode == aaf_pkg::MODE_AVG) begin
                                            div_req.start = 1'b1;
                                            state_next    = ST_DIV;
                                        end else begin
                                            out_valid_next = 1'b1;
                                            out_data_next  = s2;
                                        end
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = div_q;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cfg.kernel_wr) begin
            cnt_next = '0;
            sum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_dz_reg     <= 1'b0;
            below_reg     <= 1'b0;
            above_reg     <= 1'b0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_dz_reg     <= in_dz_next;
            below_reg     <= below_next;
            above_reg     <= above_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_filtered_value = out_data_reg;

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");

    a_cnt_below_kernel: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && $past(aresetn)) |-> cnt_reg < cfg.kernel)
        else $error("block count reached kernel size");

    a_none_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && cfg.mode == aaf_pkg::MODE_NONE && !out_valid_reg) |=> !out_valid_reg)
        else $error("result produced in mode none");

endmodule

[src/aaf_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaf_regs
// APB configuration registers; kernel size is clamped to 1..MAX_KERNEL.
// ----------------------------------------------------------------------------
module aaf_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aaf_pkg::ADDR_W-1:0]    paddr,
    input  logic [aaf_pkg::PDATA_W-1:0]   pwdata,
    output logic [aaf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output aaf_pkg::cfg_t                 cfg
);

    aaf_pkg::mode_t                        mode_reg;
    logic signed [aaf_pkg::DATA_W-1:0]     lower_reg;
    logic signed [aaf_pkg::DATA_W-1:0]     upper_reg;
    logic        [aaf_pkg::DATA_W-1:0]     dead_reg;
    logic        [aaf_pkg::CNT_W-1:0]      kernel_reg;
    logic        [aaf_pkg::CNT_W-1:0]      kernel_next;
    logic                                  wr_en;
    aaf_pkg::reg_idx_t                     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = aaf_pkg::reg_idx_t'(paddr[aaf_pkg::ADDR_W-1:2]);

    always_comb begin
        kernel_next = pwdata[aaf_pkg::CNT_W-1:0];
        if (kernel_next > aaf_pkg::CNT_W'(aaf_pkg::MAX_KERNEL)) begin
            kernel_next = aaf_pkg::CNT_W'(aaf_pkg::MAX_KERNEL);
        end else if (kernel_next == '0) begin
            kernel_next = aaf_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= aaf_pkg::MODE_AVG;
            lower_reg  <= 16'sh8000;
            upper_reg  <= 16'sh7FFF;
            dead_reg   <= '0;
            kernel_reg <= aaf_pkg::CNT_W'(1);
        end else if (wr_en) begin
            unique case (idx)
                aaf_pkg::REG_MODE:   mode_reg   <= aaf_pkg::mode_t'(pwdata[1:0]);
                aaf_pkg::REG_LOWER:  lower_reg  <= pwdata[aaf_pkg::DATA_W-1:0];
                aaf_pkg::REG_UPPER:  upper_reg  <= pwdata[aaf_pkg::DATA_W-1:0];
                aaf_pkg::REG_DEAD:   dead_reg   <= pwdata[aaf_pkg::DATA_W-1:0];
                aaf_pkg::REG_KERNEL: kernel_reg <= kernel_next;
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            aaf_pkg::REG_MODE:   prdata = {30'd0, mode_reg};
            aaf_pkg::REG_LOWER:  prdata = {{16{lower_reg[15]}}, lower_reg};
            aaf_pkg::REG_UPPER:  prdata = {{16{upper_reg[15]}}, upper_reg};
            aaf_pkg::REG_DEAD:   prdata = {16'd0, dead_reg};
            aaf_pkg::REG_KERNEL: prdata = {25'd0, kernel_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.mode      = mode_reg;
    assign cfg.lower     = lower_reg;
    assign cfg.upper     = upper_reg;
    assign cfg.dead      = dead_reg;
    assign cfg.kernel    = kernel_reg;
    assign cfg.kernel_wr = wr_en && (idx == aaf_pkg::REG_KERNEL);

endmodule

[src/aaf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaf_div
// Restoring serial divider, one quotient bit per cycle, sign applied at end.
// ----------------------------------------------------------------------------
module aaf_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  aaf_pkg::div_req_t                 req,
    output logic                              done,
    output logic signed [aaf_pkg::DATA_W-1:0] quotient
);

    logic [aaf_pkg::DIV_W-1:0]   dvd_reg, dvd_next;
    logic [aaf_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [aaf_pkg::CNT_W-1:0]   dvs_reg;
    logic [aaf_pkg::STEP_W-1:0]  step_reg;
    logic                        busy_reg;
    logic                        neg_reg;
    logic                        done_reg;
    logic [aaf_pkg::CNT_W-1:0]   rem_sh;
    logic                        ge;
    logic [aaf_pkg::DATA_W-1:0]  q_mag;

    always_comb begin
        rem_sh   = {rem_reg[aaf_pkg::CNT_W-2:0], dvd_reg[aaf_pkg::DIV_W-1]};
        ge       = rem_sh >= dvs_reg;
        rem_next = ge ? rem_sh - dvs_reg : rem_sh;
        dvd_next = {dvd_reg[aaf_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= aaf_pkg::STEP_W'(aaf_pkg::DIV_W - 1);
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                neg_reg  <= req.neg;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                dvd_reg  <= dvd_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign q_mag    = dvd_reg[aaf_pkg::DATA_W-1:0];
    assign quotient = neg_reg ? -q_mag : q_mag;
    assign done     = done_reg;

endmodule

[tb/analog_axis_filter_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_axis_filter_top_tb
// Self-checking bench for the axis sample conditioner. A directed table
// walks the dead zone, bound clamps, kernel limits and every mode. Random
// bursts follow under changing register settings and handshake throttling.
// Every output beat is checked against a table value or an in-bench model.
// ----------------------------------------------------------------------------
module analog_axis_filter_top_tb;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int PHASE_SAMPLES = 250;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_SAMPLE,
        ROW_EXPECT,
        ROW_DROP
    } row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        aaf_pkg::reg_idx_t                 idx;
        logic        [31:0]                value;
        logic signed [aaf_pkg::DATA_W-1:0] want;
    } row_t;

    localparam int DIR_N = 47;
    localparam row_t DIRECTED [DIR_N] = '{
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   32'sd0,                      16'sd0},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   -32'sd32768,                 16'sh8000},
        '{ROW_CFG,    aaf_pkg::REG_MODE,   32'(aaf_pkg::MODE_PASS),     16'sd0},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   -32'sd1,                     -16'sd1},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   32'sd32767,                  16'sd32767},
        '{ROW_CFG,    aaf_pkg::REG_MODE,   32'(aaf_pkg::MODE_NONE),     16'sd0},
        '{ROW_DROP,   aaf_pkg::REG_MODE,   32'sd1234,                   16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_MODE,   32'(aaf_pkg::MODE_AVG),      16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_DEAD,   32'sd100,                    16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_LOWER,  -32'sd1000,                  16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_UPPER,  32'sd1000,                   16'sd0},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   32'sd50,                     16'sd0},
        '{ROW_DROP,   aaf_pkg::REG_MODE,   -32'sd99,                    16'sd0},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   32'sd100,                    16'sd100},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   -32'sd5000,                  -16'sd1000},
        '{ROW_DROP,   aaf_pkg::REG_MODE,   -32'sd32768,                 16'sd0},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   32'sd5000,                   16'sd1000},
        '{ROW_DROP,   aaf_pkg::REG_MODE,   32'sd32767,                  16'sd0},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   32'sd0,                      16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_DEAD,   32'sd32768,                  16'sd0},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   -32'sd32768,                 -16'sd1000},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   32'sd32767,                  16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_DEAD,   32'sd0,                      16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_KERNEL, 32'sd4,                      16'sd0},
        '{ROW_SAMPLE, aaf_pkg::REG_MODE,   32'sd1000,                   16'sd0},
        '{ROW_SAMPLE, aaf_pkg::REG_MODE,   -32'sd3,                     16'sd0},
        '{ROW_SAMPLE, aaf_pkg::REG_MODE,   32'sd7,                      16'sd0},
        '{ROW_SAMPLE, aaf_pkg::REG_MODE,   32'sd0,                      16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_KERNEL, 32'sd3,                      16'sd0},
        '{ROW_SAMPLE, aaf_pkg::REG_MODE,   -32'sd1,                     16'sd0},
        '{ROW_SAMPLE, aaf_pkg::REG_MODE,   -32'sd1,                     16'sd0},
        '{ROW_SAMPLE, aaf_pkg::REG_MODE,   32'sd0,                      16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_MODE,   32'(aaf_pkg::MODE_LAST),     16'sd0},
        '{ROW_SAMPLE, aaf_pkg::REG_MODE,   32'sd1,                      16'sd0},
        '{ROW_SAMPLE, aaf_pkg::REG_MODE,   32'sd2,                      16'sd0},
        '{ROW_SAMPLE, aaf_pkg::REG_MODE,   -32'sd7,                     16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_KERNEL, 32'sd0,                      16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_LOWER,  32'sd500,                    16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_UPPER,  -32'sd500,                   16'sd0},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   32'sd0,                      16'sd500},
        '{ROW_EXPECT, aaf_pkg::REG_MODE,   32'sd600,                    -16'sd500},
        '{ROW_CFG,    aaf_pkg::REG_KERNEL, 32'sd127,                    16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_MODE,   32'(aaf_pkg::MODE_AVG),      16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_LOWER,  -32'sd32768,                 16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_UPPER,  32'sd32767,                  16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_DEAD,   32'sd65535,                  16'sd0},
        '{ROW_CFG,    aaf_pkg::REG_DEAD,   32'sd0,                      16'sd0}
    };

    logic                               aclk;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic signed [aaf_pkg::DATA_W-1:0]  s_sample = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic signed [aaf_pkg::DATA_W-1:0]  m_filtered_value;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [aaf_pkg::ADDR_W-1:0]         paddr = '0;
    logic [aaf_pkg::PDATA_W-1:0]        pwdata = '0;
    logic [aaf_pkg::PDATA_W-1:0]        prdata;
    logic                               pready;

    analog_axis_filter_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // filter model state
    aaf_pkg::mode_t                     cfg_mode;
    logic signed [aaf_pkg::DATA_W-1:0]  cfg_lower;
    logic signed [aaf_pkg::DATA_W-1:0]  cfg_upper;
    logic        [aaf_pkg::DATA_W-1:0]  cfg_dead;
    int                                 cfg_kernel;
    bit                                 at_rest;
    bit                                 held_low;
    bit                                 held_high;
    int                                 fill_count;
    int                                 fill_sum;

    logic signed [aaf_pkg::DATA_W-1:0]  filtered_due[$];
    logic signed [aaf_pkg::DATA_W-1:0]  due_value;

    int  s_idle_pct = 0;
    int  m_idle_pct = 0;
    bit  hold_req   = 1'b0;
    bit  hold_done  = 1'b0;
    int  mismatches = 0;
    int  checked    = 0;
    int  fed        = 0;
    int  settings   = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void apply_register(input aaf_pkg::reg_idx_t idx,
                                           input logic [31:0] val);
        int k;
        case (idx)
            aaf_pkg::REG_MODE:   cfg_mode  = aaf_pkg::mode_t'(val[1:0]);
            aaf_pkg::REG_LOWER:  cfg_lower = val[15:0];
            aaf_pkg::REG_UPPER:  cfg_upper = val[15:0];
            aaf_pkg::REG_DEAD:   cfg_dead  = val[15:0];
            aaf_pkg::REG_KERNEL: begin
                k = int'(val[6:0]);
                if (k > aaf_pkg::MAX_KERNEL) k = aaf_pkg::MAX_KERNEL;
                if (k == 0) k = 1;
                cfg_kernel = k;
                fill_count = 0;
                fill_sum   = 0;
            end
            default: ;
        endcase
    endfunction

    // returns 1 when the sample closes out a filtered value
    function automatic bit condition_sample(input logic signed [aaf_pkg::DATA_W-1:0] raw,
                                            output logic signed [aaf_pkg::DATA_W-1:0] value);
        int s;
        int mag;
        s = raw;
        value = '0;
        if (cfg_mode == aaf_pkg::MODE_NONE) return 1'b0;
        if (cfg_mode == aaf_pkg::MODE_PASS) begin
            value = raw;
            return 1'b1;
        end
        mag = (s < 0) ? -s : s;
        if (mag < int'(cfg_dead)) begin
            if (at_rest) return 1'b0;
            s = 0;
            at_rest = 1'b1;
        end else begin
            at_rest = 1'b0;
        end
        if (s < int'(cfg_lower)) begin
            if (held_low) return 1'b0;
            s = cfg_lower;
            held_low  = 1'b1;
            held_high = 1'b0;
        end else if (s > int'(cfg_upper)) begin
            if (held_high) return 1'b0;
            s = cfg_upper;
            held_high = 1'b1;
            held_low  = 1'b0;
        end else begin
            held_low  = 1'b0;
            held_high = 1'b0;
        end
        fill_sum   = fill_sum + s;
        fill_count = (fill_count + 1) & 127;
        if (fill_count < cfg_kernel) return 1'b0;
        if (cfg_kernel > 1 && cfg_mode == aaf_pkg::MODE_AVG) s = fill_sum / cfg_kernel;
        fill_count = 0;
        fill_sum   = 0;
        value = 16'(s);
        return 1'b1;
    endfunction

    task automatic cfg_write(input aaf_pkg::reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        apply_register(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // offer one beat; how selects model prediction or a typed expectation
    task automatic send_sample(input logic signed [aaf_pkg::DATA_W-1:0] v,
                               input row_kind_t how,
                               input logic signed [aaf_pkg::DATA_W-1:0] want);
        logic signed [aaf_pkg::DATA_W-1:0] got;
        bit                                has;
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
        if (cfg_mode != aaf_pkg::MODE_NONE) fed++;
        has = condition_sample(v, got);
        if (how == ROW_SAMPLE && has) filtered_due.push_back(got);
        if (how == ROW_EXPECT) filtered_due.push_back(want);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (filtered_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [aaf_pkg::DATA_W-1:0] pick_sample();
        int r;
        int v;
        int d;
        r = $urandom_range(99);
        d = int'(cfg_dead) + 4;
        if (r < 35) v = int'($signed(16'($urandom)));
        else if (r < 55) v = int'(cfg_lower) + int'($urandom_range(100)) - 50;
        else if (r < 75) v = int'(cfg_upper) + int'($urandom_range(100)) - 50;
        else if (r < 90) v = int'($urandom_range(2 * d)) - d;
        else v = ($urandom_range(1) != 0) ? 32767 : -32768;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic shuffle_config();
        int             r;
        int             lo;
        int             hi;
        aaf_pkg::mode_t m;
        settings++;
        r = $urandom_range(99);
        if ($urandom_range(99) < 70) begin
            if (r < 5) m = aaf_pkg::MODE_NONE;
            else if (r < 15) m = aaf_pkg::MODE_PASS;
            else if (r < 60) m = aaf_pkg::MODE_AVG;
            else m = aaf_pkg::MODE_LAST;
            cfg_write(aaf_pkg::REG_MODE, 32'(m));
        end
        r = $urandom_range(99);
        if (r < 25) begin
            lo = -32768;
            hi = 32767;
        end else if (r < 75) begin
            lo = 0 - int'($urandom_range(20000));
            hi = int'($urandom_range(20000));
        end else begin
            lo = int'($signed(16'($urandom)));
            hi = int'($signed(16'($urandom)));
        end
        if ($urandom_range(99) < 70) cfg_write(aaf_pkg::REG_LOWER, 32'(lo));
        if ($urandom_range(99) < 70) cfg_write(aaf_pkg::REG_UPPER, 32'(hi));
        r = $urandom_range(99);
        if ($urandom_range(99) < 60) begin
            if (r < 40) cfg_write(aaf_pkg::REG_DEAD, 32'd0);
            else if (r < 75) cfg_write(aaf_pkg::REG_DEAD, 32'($urandom_range(1, 2000)));
            else if (r < 85) cfg_write(aaf_pkg::REG_DEAD, 32'd32768);
            else cfg_write(aaf_pkg::REG_DEAD, 32'($urandom_range(65535)));
        end
        r = $urandom_range(99);
        if ($urandom_range(99) < 50) begin
            if (r < 40) cfg_write(aaf_pkg::REG_KERNEL, 32'($urandom_range(1, 4)));
            else if (r < 75) cfg_write(aaf_pkg::REG_KERNEL, 32'($urandom_range(5, 16)));
            else if (r < 85) cfg_write(aaf_pkg::REG_KERNEL, 32'(aaf_pkg::MAX_KERNEL));
            else if (r < 90) cfg_write(aaf_pkg::REG_KERNEL, 32'd0);
            else if (r < 95) cfg_write(aaf_pkg::REG_KERNEL, 32'($urandom_range(65, 127)));
            else cfg_write(aaf_pkg::REG_KERNEL, 32'($urandom_range(17, 63)));
        end
    endtask

    initial begin : ready_drive
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= m_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            checked++;
            if (filtered_due.size() == 0) begin
                mismatches++;
                $error("filtered_value: expected none, got %0d", m_filtered_value);
            end else begin
                due_value = filtered_due.pop_front();
                if (m_filtered_value !== due_value) begin
                    mismatches++;
                    $error("filtered_value: expected %0d, got %0d", due_value,
                           m_filtered_value);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) quiet = 0;
            else quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int goal;
        cfg_mode   = aaf_pkg::MODE_AVG;
        cfg_lower  = 16'sh8000;
        cfg_upper  = 16'sh7fff;
        cfg_dead   = '0;
        cfg_kernel = 1;
        at_rest    = 1'b0;
        held_low   = 1'b0;
        held_high  = 1'b0;
        fill_count = 0;
        fill_sum   = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                settle();
                cfg_write(DIRECTED[i].idx, DIRECTED[i].value);
            end else begin
                send_sample(DIRECTED[i].value[15:0], DIRECTED[i].kind, DIRECTED[i].want);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            s_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 75 : 0;
            m_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 13 : 0;
            if (ph == 2) begin
                // back up the output so the input side has to stall
                settle();
                cfg_write(aaf_pkg::REG_MODE, 32'(aaf_pkg::MODE_PASS));
                hold_req = 1'b1;
                repeat (40) send_sample(pick_sample(), ROW_SAMPLE, '0);
                settle();
            end
            goal = fed + PHASE_SAMPLES;
            while (fed < goal) begin
                settle();
                shuffle_config();
                repeat ($urandom_range(20, 120)) send_sample(pick_sample(), ROW_SAMPLE, '0);
            end
        end

        settle();
        $display("Fed %0d filtered samples over %0d random register settings plus a table;",
                 fed, settings);
        $display("checked %0d output beats, %0d mismatches.", checked, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
src/aaf_pkg.sv
src/aaf_regs.sv
src/aaf_div.sv
src/analog_axis_filter_top.sv
tb/analog_axis_filter_top_tb.sv
